// ===== sv/gte_pkg.sv =====
// Shared types, constants and the microprogram of the graph traversal engine.
package gte_pkg;

   localparam int VERTEX_W   = 4;
   localparam int NV_W       = 5;
   localparam int ACTION_W   = 2;
   localparam int VERTEX_CAP = 16;
   localparam int UPC_W      = 4;

   localparam logic [ACTION_W-1:0] ACT_ADD_EDGE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TRAVERSE = 2'd2;

   localparam logic [NV_W-1:0] NV_RESET = 5'd16;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [3:0] {
      UOP_FETCH,
      UOP_ADD_A,
      UOP_ADD_B,
      UOP_CLEAR,
      UOP_DFS_INIT,
      UOP_DFS_STEP,
      UOP_BFS_INIT,
      UOP_BFS_POP,
      UOP_BFS_SCAN,
      UOP_FINISH
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_DISPATCH,
      COND_STACK_EMPTY,
      COND_QUEUE_EMPTY,
      COND_CAND_EMPTY
   } cond_type;

   localparam upc_type UPC_FETCH    = 4'd0;
   localparam upc_type UPC_ADD_A    = 4'd1;
   localparam upc_type UPC_ADD_B    = 4'd2;
   localparam upc_type UPC_CLEAR    = 4'd3;
   localparam upc_type UPC_DFS_INIT = 4'd4;
   localparam upc_type UPC_DFS_STEP = 4'd5;
   localparam upc_type UPC_BFS_INIT = 4'd6;
   localparam upc_type UPC_BFS_POP  = 4'd7;
   localparam upc_type UPC_BFS_SCAN = 4'd8;
   localparam upc_type UPC_FINISH   = 4'd9;

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      upc_type  jmp_t;
      upc_type  jmp_f;
   } ucode_word_type;

   typedef struct packed {
      logic    accept;
      upc_type entry;
      logic    stack_empty;
      logic    queue_empty;
      logic    cand_empty;
      logic    stall;
   } seq_status_type;

   typedef struct packed {
      uop_type op;
   } seq_ctl_type;

   function automatic ucode_word_type ucode_rom(input upc_type upc);
      ucode_word_type w;
      case (upc)
         UPC_FETCH:    w = '{UOP_FETCH,    COND_DISPATCH,    UPC_FETCH,    UPC_FETCH};
         UPC_ADD_A:    w = '{UOP_ADD_A,    COND_NEVER,       UPC_FETCH,    UPC_ADD_B};
         UPC_ADD_B:    w = '{UOP_ADD_B,    COND_ALWAYS,      UPC_FETCH,    UPC_FETCH};
         UPC_CLEAR:    w = '{UOP_CLEAR,    COND_ALWAYS,      UPC_FETCH,    UPC_FETCH};
         UPC_DFS_INIT: w = '{UOP_DFS_INIT, COND_ALWAYS,      UPC_DFS_STEP, UPC_DFS_STEP};
         UPC_DFS_STEP: w = '{UOP_DFS_STEP, COND_STACK_EMPTY, UPC_FINISH,   UPC_DFS_STEP};
         UPC_BFS_INIT: w = '{UOP_BFS_INIT, COND_ALWAYS,      UPC_BFS_POP,  UPC_BFS_POP};
         UPC_BFS_POP:  w = '{UOP_BFS_POP,  COND_QUEUE_EMPTY, UPC_FINISH,   UPC_BFS_SCAN};
         UPC_BFS_SCAN: w = '{UOP_BFS_SCAN, COND_CAND_EMPTY,  UPC_BFS_POP,  UPC_BFS_SCAN};
         UPC_FINISH:   w = '{UOP_FINISH,   COND_ALWAYS,      UPC_FETCH,    UPC_FETCH};
         default:      w = '{UOP_FETCH,    COND_ALWAYS,      UPC_FETCH,    UPC_FETCH};
      endcase
      return w;
   endfunction

endpackage

// ===== sv/gte_if.sv =====
// Request and response channel interfaces of the graph traversal engine.
interface gte_req_if;
   logic                               valid;
   logic                               ready;
   logic [gte_pkg::ACTION_W-1:0]       action;
   logic [gte_pkg::VERTEX_W-1:0]       vertex_a;
   logic [gte_pkg::VERTEX_W-1:0]       vertex_b;
   logic                               depth_first;

   modport source (output valid, action, vertex_a, vertex_b, depth_first, input ready);
   modport sink (input valid, action, vertex_a, vertex_b, depth_first, output ready);
endinterface

interface gte_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [gte_pkg::VERTEX_W-1:0]       vertex;
   logic                               last;

   modport source (output valid, vertex, last, input ready);
   modport sink (input valid, vertex, last, output ready);
endinterface

// ===== sv/gte_sequencer.sv =====
// Microprogram sequencer: step counter, control store and conditional jumps.
module gte_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  gte_pkg::seq_status_type stat,
   output gte_pkg::seq_ctl_type    ctl
);

   gte_pkg::upc_type       upc_ff;
   gte_pkg::upc_type       upc_in;
   gte_pkg::ucode_word_type word;
   logic                   hit;

   always_comb begin
      word = gte_pkg::ucode_rom(upc_ff);
      hit  = 1'b0;
      case (word.cond)
         gte_pkg::COND_NEVER:       hit = 1'b0;
         gte_pkg::COND_ALWAYS:      hit = 1'b1;
         gte_pkg::COND_DISPATCH:    hit = 1'b1;
         gte_pkg::COND_STACK_EMPTY: hit = stat.stack_empty;
         gte_pkg::COND_QUEUE_EMPTY: hit = stat.queue_empty;
         gte_pkg::COND_CAND_EMPTY:  hit = stat.cand_empty;
         default:                   hit = 1'b1;
      endcase
      if (stat.stall) begin
         upc_in = upc_ff;
      end else if (word.cond == gte_pkg::COND_DISPATCH) begin
         upc_in = stat.accept ? stat.entry : gte_pkg::UPC_FETCH;
      end else begin
         upc_in = hit ? word.jmp_t : word.jmp_f;
      end
      ctl.op = word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= gte_pkg::UPC_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== sv/graph_traversal_engine.sv =====
// Top level of the graph traversal engine: adjacency store, traversal datapath and ports.
// The engine keeps an undirected graph of up to sixteen vertices as an adjacency bit
// matrix and answers three kinds of request: add an edge, clear the graph, or walk the
// graph depth-first or breadth-first from a start vertex, returning every reachable vertex
// once in visit order with last set on the final one. Neighbours are taken in ascending
// order. A microprogram steps a small datapath that reads one adjacency row per cycle
// unless the response register stalls it, and one request is handled at a time. A
// depth-first walk takes one step to advance into and one to back out of each vertex;
// a breadth-first walk takes a pop, a scan per neighbour found and a closing scan per
// vertex. The single response register holds each step that delivers a vertex until
// the previous vertex is taken, so a slow consumer lengthens a walk. A new request is
// accepted while the final vertex of the previous walk still waits in the response
// register.
module graph_traversal_engine #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [gte_pkg::NV_W-1:0]  csr_wr_data,
   gte_req_if.sink                   req_if,
   gte_rsp_if.source                 rsp_if
);

   localparam int NODES  = (MAX_VERTICES < gte_pkg::VERTEX_CAP) ? MAX_VERTICES
                                                               : gte_pkg::VERTEX_CAP;
   localparam int VIDX_W = $clog2(NODES);
   localparam int PTR_W  = $clog2(NODES + 1);

   typedef logic [NODES-1:0]  row_type;
   typedef logic [VIDX_W-1:0] vidx_type;
   typedef logic [PTR_W-1:0]  ptr_type;

   gte_pkg::seq_status_type stat;
   gte_pkg::seq_ctl_type    ctl;
   gte_pkg::upc_type        entry;

   logic [gte_pkg::NV_W-1:0]     nv_ff;
   logic [gte_pkg::NV_W-1:0]     n_eff;
   row_type                      lim;

   row_type                      adj_ff [NODES];
   row_type                      adj_in [NODES];
   row_type                      visited_ff;
   row_type                      visited_in;
   row_type                      cand_ff;
   row_type                      cand_in;
   vidx_type                     stk_ff [NODES];
   vidx_type                     q_ff [NODES];
   ptr_type                      sp_ff;
   ptr_type                      sp_in;
   ptr_type                      head_ff;
   ptr_type                      head_in;
   ptr_type                      tail_ff;
   ptr_type                      tail_in;
   vidx_type                     pend_ff;
   vidx_type                     pend_in;
   logic [gte_pkg::VERTEX_W-1:0] a_ff;
   logic [gte_pkg::VERTEX_W-1:0] b_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [gte_pkg::VERTEX_W-1:0] rsp_vertex_ff;
   logic [gte_pkg::VERTEX_W-1:0] rsp_vertex_in;
   logic                         rsp_last_ff;
   logic                         rsp_last_in;

   logic     accept;
   logic     a_ok;
   logic     b_ok;
   vidx_type a_idx;
   vidx_type b_idx;
   vidx_type top_v;
   vidx_type head_v;
   vidx_type row_sel;
   row_type  cand_now;
   row_type  pick_src;
   vidx_type nx;
   row_type  nx_bit;
   logic     emit_req;
   logic     out_free;
   logic     stall;
   logic     out_load;
   logic     out_last;
   logic     stk_we;
   logic     q_we;
   vidx_type q_wdata;

   // Effective vertex count, clamped to the range 1 to MAX_VERTICES.
   always_comb begin
      if (nv_ff == '0) begin
         n_eff = gte_pkg::NV_W'(1);
      end else if (int'(nv_ff) > MAX_VERTICES) begin
         n_eff = gte_pkg::NV_W'(MAX_VERTICES);
      end else begin
         n_eff = nv_ff;
      end
      for (int i = 0; i < NODES; i++) begin
         lim[i] = (i < int'(n_eff));
      end
   end

   assign accept = req_if.valid && req_if.ready;
   assign a_ok   = {1'b0, req_if.vertex_a} < n_eff;
   assign b_ok   = {1'b0, req_if.vertex_b} < n_eff;
   assign a_idx  = a_ff[VIDX_W-1:0];
   assign b_idx  = b_ff[VIDX_W-1:0];

   always_comb begin
      entry = gte_pkg::UPC_FETCH;
      case (req_if.action)
         gte_pkg::ACT_ADD_EDGE: begin
            if (a_ok && b_ok) begin
               entry = gte_pkg::UPC_ADD_A;
            end
         end
         gte_pkg::ACT_CLEAR: begin
            entry = gte_pkg::UPC_CLEAR;
         end
         gte_pkg::ACT_TRAVERSE: begin
            if (a_ok) begin
               entry = req_if.depth_first ? gte_pkg::UPC_DFS_INIT
                                          : gte_pkg::UPC_BFS_INIT;
            end
         end
         default: begin
            entry = gte_pkg::UPC_FETCH;
         end
      endcase
   end

   // One adjacency row is read per cycle, from the stack top or the queue head.
   assign top_v    = stk_ff[VIDX_W'(sp_ff - PTR_W'(1))];
   assign head_v   = q_ff[head_ff[VIDX_W-1:0]];
   assign row_sel  = (ctl.op == gte_pkg::UOP_DFS_STEP) ? top_v : head_v;
   assign cand_now = adj_ff[row_sel] & lim & ~visited_ff;
   assign pick_src = (ctl.op == gte_pkg::UOP_BFS_SCAN) ? cand_ff : cand_now;

   always_comb begin
      nx = '0;
      for (int i = NODES - 1; i >= 0; i--) begin
         if (pick_src[i]) begin
            nx = VIDX_W'(i);
         end
      end
      nx_bit     = '0;
      nx_bit[nx] = 1'b1;
   end

   assign stat.entry       = entry;
   assign stat.accept      = accept;
   assign stat.stack_empty = (sp_ff == '0);
   assign stat.queue_empty = (head_ff == tail_ff);
   assign stat.cand_empty  = (cand_ff == '0);

   assign emit_req = ((ctl.op == gte_pkg::UOP_DFS_STEP) && (sp_ff != '0) && (cand_now != '0))
                  || ((ctl.op == gte_pkg::UOP_BFS_SCAN) && (cand_ff != '0))
                  || (ctl.op == gte_pkg::UOP_FINISH);
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign stall      = emit_req && !out_free;
   assign stat.stall = stall;

   assign req_if.ready = (ctl.op == gte_pkg::UOP_FETCH);

   always_comb begin
      adj_in     = adj_ff;
      visited_in = visited_ff;
      cand_in    = cand_ff;
      sp_in      = sp_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      pend_in    = pend_ff;
      out_load   = 1'b0;
      out_last   = 1'b0;
      stk_we     = 1'b0;
      q_we       = 1'b0;
      q_wdata    = nx;
      if (!stall) begin
         case (ctl.op)
            gte_pkg::UOP_ADD_A: begin
               adj_in[a_idx][b_idx] = 1'b1;
            end
            gte_pkg::UOP_ADD_B: begin
               adj_in[b_idx][a_idx] = 1'b1;
            end
            gte_pkg::UOP_CLEAR: begin
               for (int i = 0; i < NODES; i++) begin
                  adj_in[i] = '0;
               end
            end
            gte_pkg::UOP_DFS_INIT: begin
               visited_in        = '0;
               visited_in[a_idx] = 1'b1;
               pend_in           = a_idx;
               sp_in             = PTR_W'(1);
            end
            gte_pkg::UOP_DFS_STEP: begin
               if (sp_ff != '0) begin
                  if (cand_now != '0) begin
                     visited_in = visited_ff | nx_bit;
                     pend_in    = nx;
                     out_load   = 1'b1;
                     stk_we     = 1'b1;
                     sp_in      = sp_ff + PTR_W'(1);
                  end else begin
                     sp_in = sp_ff - PTR_W'(1);
                  end
               end
            end
            gte_pkg::UOP_BFS_INIT: begin
               visited_in        = '0;
               visited_in[a_idx] = 1'b1;
               pend_in           = a_idx;
               q_we              = 1'b1;
               q_wdata           = a_idx;
               head_in           = '0;
               tail_in           = PTR_W'(1);
            end
            gte_pkg::UOP_BFS_POP: begin
               if (head_ff != tail_ff) begin
                  cand_in = cand_now;
                  head_in = head_ff + PTR_W'(1);
               end
            end
            gte_pkg::UOP_BFS_SCAN: begin
               if (cand_ff != '0) begin
                  cand_in    = cand_ff & ~nx_bit;
                  visited_in = visited_ff | nx_bit;
                  pend_in    = nx;
                  out_load   = 1'b1;
                  q_we       = 1'b1;
                  tail_in    = tail_ff + PTR_W'(1);
               end
            end
            gte_pkg::UOP_FINISH: begin
               out_load   = 1'b1;
               out_last   = 1'b1;
               visited_in = '0;
               sp_in      = '0;
               head_in    = '0;
               tail_in    = '0;
            end
            default: begin
               adj_in = adj_ff;
            end
         endcase
      end
   end

   // The vertex held in pend_ff goes out once it is known whether another follows.
   always_comb begin
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = gte_pkg::VERTEX_W'(pend_ff);
         rsp_last_in   = out_last;
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
         rsp_vertex_in = rsp_vertex_ff;
         rsp_last_in   = rsp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff        <= gte_pkg::NV_RESET;
         visited_ff   <= '0;
         sp_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NODES; i++) begin
            adj_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            nv_ff <= csr_wr_data;
         end
         visited_ff   <= visited_in;
         sp_ff        <= sp_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
         adj_ff       <= adj_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      pend_ff       <= pend_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      if (accept) begin
         a_ff <= req_if.vertex_a;
         b_ff <= req_if.vertex_b;
      end
      if (ctl.op == gte_pkg::UOP_DFS_INIT) begin
         stk_ff[0] <= a_idx;
      end else if (stk_we) begin
         stk_ff[sp_ff[VIDX_W-1:0]] <= nx;
      end
      if (q_we) begin
         q_ff[tail_ff[VIDX_W-1:0]] <= q_wdata;
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.vertex = rsp_vertex_ff;
   assign rsp_if.last   = rsp_last_ff;

   gte_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

`ifndef SYNTHESIS
   a_stack_bound : assert property (@(posedge clock) disable iff (reset)
      sp_ff <= PTR_W'(NODES))
      else $error("Path stack deeper than the vertex count.");

   a_queue_order : assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("Queue head has passed the tail.");

   a_idle_clean : assert property (@(posedge clock) disable iff (reset)
      (ctl.op == gte_pkg::UOP_FETCH) |-> (visited_ff == '0 && sp_ff == '0 && tail_ff == '0))
      else $error("Traversal state left behind after a walk.");

   a_top_visited : assert property (@(posedge clock) disable iff (reset)
      (ctl.op == gte_pkg::UOP_DFS_STEP && sp_ff != '0) |-> visited_ff[top_v])
      else $error("Stack top is not marked visited.");

   a_pend_visited : assert property (@(posedge clock) disable iff (reset)
      (ctl.op == gte_pkg::UOP_FINISH) |-> visited_ff[pend_ff])
      else $error("Final vertex of a walk is not marked visited.");
`endif

endmodule
